[hw/rtl/izna_pkg.sv]
// ----------------------------------------------------------------------------
// izna_pkg
// Shared types, constants and helpers for the Izhikevich neuron array.
// ----------------------------------------------------------------------------
`default_nettype none

package izna_pkg;

    // Array size and state address width
    localparam int NEURONS = 256;
    localparam int ADDR_W  = (NEURONS > 1) ? $clog2(NEURONS) : 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Rest state, Q8.8
    localparam logic signed [15:0] REST_V     = -16'sd16640;  // -65.0
    localparam logic signed [15:0] REST_U     = -16'sd3328;   // -13.0
    localparam logic signed [15:0] FIRE_LEVEL = 16'sd7680;    // 30.0

    // Quadratic coefficient 0.04 in Q0.16 and the 140 bias in Q8.8
    localparam logic [11:0]        SQ_COEF = 12'd2621;
    localparam logic signed [21:0] BIAS_Q  = 22'sd35840;

    // Register reset values
    localparam logic [15:0]        A_RESET = 16'd1311;
    localparam logic [15:0]        B_RESET = 16'd13107;
    localparam logic signed [15:0] C_RESET = -16'sd16640;
    localparam logic signed [15:0] D_RESET = 16'sd2048;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RECOVERY_RATE        = 3'd0,
        REG_RECOVERY_SENSITIVITY = 3'd1,
        REG_RESET_VOLTAGE        = 3'd2,
        REG_RECOVERY_JUMP        = 3'd3,
        REG_COUNT_ENABLE         = 3'd4
    } cfg_reg_t;

    // One neuron's stored state
    typedef struct packed {
        logic signed [15:0] v;
        logic signed [15:0] u;
        logic [15:0]        cnt;
    } nstate_t;

    // Access request to the state store
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
    } mem_req_t;

    // Saturate a wide signed value to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [23:0] x);
        logic signed [15:0] r;
        if (x > 24'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (x < -24'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = x[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/izna_state_store.sv]
// ----------------------------------------------------------------------------
// izna_state_store
// Neuron state memory with registered read. A valid bit per entry makes
// never-written neurons read back as the rest state.
// ----------------------------------------------------------------------------
`default_nettype none

module izna_state_store (
    input  logic              clk,
    input  logic              rst_n,
    input  izna_pkg::mem_req_t req,
    input  izna_pkg::nstate_t  wr_data,
    output izna_pkg::nstate_t  rd_data
);

    izna_pkg::nstate_t mem [izna_pkg::NEURONS];
    izna_pkg::nstate_t rd_word_reg;
    logic [izna_pkg::NEURONS-1:0] valid_reg;
    logic rd_valid_reg;

    // Storage array, no reset
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_word_reg <= mem[req.rd_addr];
        end
    end

    // Written-entry flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // Unwritten entries read as rest state
    always_comb
    begin
        if (rd_valid_reg)
        begin
            rd_data = rd_word_reg;
        end
        else
        begin
            rd_data.v   = izna_pkg::REST_V;
            rd_data.u   = izna_pkg::REST_U;
            rd_data.cnt = '0;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/izhikevich_neuron_array_step.sv]
// Sequence: an update request steps LOAD, then SQ, SQC, HALF per half step,
//   then BV, DIFF, AMUL, UPD, WB; a reset request LOAD, RSTU, UPD, WB; an
//   out-of-range index goes straight to WB. A new request is taken only in
//   idle; the single shared multiplier is used six times per update.
// Reset: asynchronous active-low; configuration registers take defaults and
//   every neuron reads as rest (v=-65, u=-13, count 0) until first written.
// ----------------------------------------------------------------------------
// izhikevich_neuron_array_step
// Array of regular-spiking Izhikevich neurons in Q8.8, stepped one request at
// a time through a read-modify-write of the state memory.
// ----------------------------------------------------------------------------
`default_nettype none

module izhikevich_neuron_array_step (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [izna_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [izna_pkg::CFG_DATA_W-1:0]     cfg_data,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [7:0]                          neuron_index,
    input  logic signed [15:0]                  syn_current,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          neuron_id,
    output logic                                spike,
    output logic [15:0]                         spike_count,
    output logic signed [15:0]                  membrane
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_LOAD = 11'b000_0000_0010,
        S_SQ   = 11'b000_0000_0100,
        S_SQC  = 11'b000_0000_1000,
        S_HALF = 11'b000_0001_0000,
        S_BV   = 11'b000_0010_0000,
        S_DIFF = 11'b000_0100_0000,
        S_AMUL = 11'b000_1000_0000,
        S_RSTU = 11'b001_0000_0000,
        S_UPD  = 11'b010_0000_0000,
        S_WB   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [15:0]        a_reg;
    logic [15:0]        b_reg;
    logic signed [15:0] c_reg;
    logic signed [15:0] d_reg;
    logic               count_en_reg;

    // request and working registers
    logic               kind_reg;
    logic [7:0]         idx_reg;
    logic signed [15:0] cur_reg;
    logic               in_range_reg;
    logic               second_reg;
    logic signed [15:0] v_reg;
    logic signed [15:0] u_reg;
    logic [15:0]        cnt_reg;
    logic               fired_reg;
    logic signed [17:0] diff_reg;
    logic signed [50:0] prod_reg;

    // output register
    logic               out_valid_reg;
    logic [7:0]         out_id_reg;
    logic               out_spike_reg;
    logic [15:0]        out_cnt_reg;
    logic signed [15:0] out_v_reg;

    // datapath nets
    logic               in_accept;
    logic               in_range;
    logic               out_push;
    logic signed [31:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [50:0] mul_prod;
    logic signed [21:0] sq_term;
    logic signed [21:0] sum_q;
    logic signed [21:0] v_half;
    logic signed [15:0] v_step;
    logic signed [16:0] bv_term;
    logic signed [18:0] du_term;
    logic signed [15:0] u_step;
    logic signed [15:0] u_rest;
    logic signed [15:0] u_jump;
    logic [15:0]        cnt_inc;

    izna_pkg::mem_req_t mem_req;
    izna_pkg::nstate_t  mem_wdata;
    izna_pkg::nstate_t  mem_rdata;

    // ------------------------------------------------------------------------
    // handshake
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign in_range  = ({24'd0, neuron_index} < 32'(izna_pkg::NEURONS));
    assign out_push  = (state_reg == S_WB) && (!out_valid_reg || !out_stall);

    // ------------------------------------------------------------------------
    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg        <= izna_pkg::A_RESET;
            b_reg        <= izna_pkg::B_RESET;
            c_reg        <= izna_pkg::C_RESET;
            d_reg        <= izna_pkg::D_RESET;
            count_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (izna_pkg::cfg_reg_t'(cfg_index))
                izna_pkg::REG_RECOVERY_RATE:        a_reg        <= cfg_data;
                izna_pkg::REG_RECOVERY_SENSITIVITY: b_reg        <= cfg_data;
                izna_pkg::REG_RESET_VOLTAGE:        c_reg        <= cfg_data;
                izna_pkg::REG_RECOVERY_JUMP:        d_reg        <= cfg_data;
                izna_pkg::REG_COUNT_ENABLE:         count_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // state store
    always_comb
    begin
        mem_req.rd_en   = in_accept && in_range;
        mem_req.rd_addr = izna_pkg::ADDR_W'(neuron_index);
        mem_req.wr_en   = (state_reg == S_WB) && in_range_reg;
        mem_req.wr_addr = izna_pkg::ADDR_W'(idx_reg);
        mem_wdata.v     = v_reg;
        mem_wdata.u     = u_reg;
        mem_wdata.cnt   = cnt_reg;
    end

    izna_state_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .wr_data (mem_wdata),
        .rd_data (mem_rdata)
    );

    // ------------------------------------------------------------------------
    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ:
            begin
                mul_a = 32'(v_reg);
                mul_b = 19'(v_reg);
            end
            S_SQC:
            begin
                mul_a = prod_reg[31:0];
                mul_b = {7'd0, izna_pkg::SQ_COEF};
            end
            S_BV:
            begin
                mul_a = 32'(v_reg);
                mul_b = {3'd0, b_reg};
            end
            S_RSTU:
            begin
                mul_a = 32'(izna_pkg::REST_V);
                mul_b = {3'd0, b_reg};
            end
            S_AMUL:
            begin
                mul_a = 32'(diff_reg);
                mul_b = {3'd0, a_reg};
            end
            default: ;
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // ------------------------------------------------------------------------
    // half step: v + floor((0.04v^2 + 5v + 140 - u + I) / 2), saturated
    assign sq_term = prod_reg[45:24];
    assign sum_q   = sq_term + (22'(v_reg) <<< 2) + 22'(v_reg) + izna_pkg::BIAS_Q
                     - 22'(u_reg) + 22'(cur_reg);
    assign v_half  = 22'(v_reg) + (sum_q >>> 1);
    assign v_step  = izna_pkg::sat16(24'(v_half));

    // recovery terms
    assign bv_term = prod_reg[32:16];
    assign du_term = prod_reg[34:16];
    assign u_step  = izna_pkg::sat16(24'(u_reg) + 24'(du_term));
    assign u_jump  = izna_pkg::sat16(24'(u_step) + 24'(d_reg));
    assign u_rest  = prod_reg[31:16];
    assign cnt_inc = (count_en_reg && (cnt_reg != 16'hFFFF)) ? cnt_reg + 16'd1 : cnt_reg;

    // ------------------------------------------------------------------------
    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_range ? S_LOAD : S_WB;
                end
            end
            S_LOAD: state_next = kind_reg ? S_RSTU : S_SQ;
            S_SQ:   state_next = S_SQC;
            S_SQC:  state_next = S_HALF;
            S_HALF: state_next = second_reg ? S_BV : S_SQ;
            S_BV:   state_next = S_DIFF;
            S_DIFF: state_next = S_AMUL;
            S_AMUL: state_next = S_UPD;
            S_RSTU: state_next = S_UPD;
            S_UPD:  state_next = S_WB;
            S_WB:
            begin
                if (out_push)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------------
    // working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_prod;
        case (state_reg)
            S_IDLE:
            begin
                kind_reg     <= kind;
                idx_reg      <= neuron_index;
                cur_reg      <= syn_current;
                in_range_reg <= in_range;
                second_reg   <= 1'b0;
                v_reg        <= '0;
                cnt_reg      <= '0;
                fired_reg    <= 1'b0;
            end
            S_LOAD:
            begin
                v_reg   <= mem_rdata.v;
                u_reg   <= mem_rdata.u;
                cnt_reg <= mem_rdata.cnt;
            end
            S_HALF:
            begin
                v_reg      <= v_step;
                second_reg <= 1'b1;
            end
            S_DIFF:
            begin
                diff_reg <= 18'(bv_term) - 18'(u_reg);
            end
            S_UPD:
            begin
                if (kind_reg)
                begin
                    // rest state
                    v_reg     <= izna_pkg::REST_V;
                    u_reg     <= u_rest;
                    cnt_reg   <= '0;
                    fired_reg <= 1'b0;
                end
                else if (v_reg >= izna_pkg::FIRE_LEVEL)
                begin
                    // spike
                    v_reg     <= c_reg;
                    u_reg     <= u_jump;
                    cnt_reg   <= cnt_inc;
                    fired_reg <= 1'b1;
                end
                else
                begin
                    u_reg     <= u_step;
                    fired_reg <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------------
    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            out_id_reg    <= idx_reg;
            out_spike_reg <= fired_reg;
            out_cnt_reg   <= cnt_reg;
            out_v_reg     <= v_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign neuron_id   = out_id_reg;
    assign spike       = out_spike_reg;
    assign spike_count = out_cnt_reg;
    assign membrane    = out_v_reg;

endmodule

`default_nettype wire

[hw/rtl/izna_checker.sv]
// ----------------------------------------------------------------------------
// izna_checker
// Port-level checks for the neuron array: one request in flight, results
// only from a busy block, held results while stalled, clean reset.
// ----------------------------------------------------------------------------
`default_nettype none

module izna_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [7:0]         neuron_id,
    input logic               spike,
    input logic [15:0]        spike_count,
    input logic signed [15:0] membrane
);

    // an accepted request blocks the next one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while another is in flight");

    // a new result only appears after a busy cycle
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while block was idle");

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(neuron_id) && $stable(spike)
            && $stable(spike_count) && $stable(membrane))
        else $error("stalled result changed");

    // leaving reset: idle and empty
    a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid && !in_stall)
        else $error("block not idle after reset");

endmodule

bind izhikevich_neuron_array_step izna_checker u_izna_checker (.*);

`default_nettype wire
